>>> rtl/ssd_pkg.sv
`timescale 1ns / 1ps

package ssd_pkg;

   localparam int NUM_CHANNELS         = 4;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int REG_WIDTH            = 10;
   localparam int CSR_INDEX_WIDTH      = 2;

   localparam logic [REG_WIDTH-1:0] SLEW_STEP_RESET = 10'd10;
   localparam logic [REG_WIDTH-1:0] DEADBAND_RESET  = 10'd8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SLEW_STEP = 2'd0,
      CSR_DEADBAND  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] slew_step;
      logic [REG_WIDTH-1:0] deadband;
   } cfg_type;

endpackage

>>> rtl/ssd_chan.sv
`timescale 1ns / 1ps

module ssd_chan #(
   parameter int SAMPLE_WIDTH = ssd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  ssd_pkg::cfg_type                 cfg,
   input  logic signed [SAMPLE_WIDTH-1:0]   sample,
   input  logic signed [SAMPLE_WIDTH-1:0]   prev,
   output logic signed [SAMPLE_WIDTH-1:0]   result
);
   import ssd_pkg::*;

   localparam int EW = SAMPLE_WIDTH + REG_WIDTH + 2;
   localparam int MW = SAMPLE_WIDTH + 1;
   localparam int SH = MW + 2;
   localparam int RW = SH - 1;
   localparam int PW = MW + RW;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'd4) / 64'd5;
   localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

   localparam logic signed [EW-1:0] MAX_E = EW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] MIN_E = -MAX_E - EW'(1);

   logic signed [EW-1:0]     s_e;
   logic signed [EW-1:0]     p_e;
   logic signed [EW-1:0]     step_e;
   logic signed [EW-1:0]     zone_e;
   logic signed [EW-1:0]     diff;
   logic signed [EW-1:0]     mag;
   logic signed [EW-1:0]     up;
   logic signed [EW-1:0]     dn;
   logic [SAMPLE_WIDTH-1:0]  p_abs;
   logic [MW-1:0]            m3;
   logic [PW-1:0]            prod;
   logic [SAMPLE_WIDTH-1:0]  q;
   logic signed [SAMPLE_WIDTH-1:0] decay;

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [EW-1:0] v);
      if (v > MAX_E) begin
         sat = MAX_E[SAMPLE_WIDTH-1:0];
      end else if (v < MIN_E) begin
         sat = MIN_E[SAMPLE_WIDTH-1:0];
      end else begin
         sat = v[SAMPLE_WIDTH-1:0];
      end
   endfunction

   assign s_e    = EW'(sample);
   assign p_e    = EW'(prev);
   assign step_e = $signed({{(EW - REG_WIDTH){1'b0}}, cfg.slew_step});
   assign zone_e = $signed({{(EW - REG_WIDTH){1'b0}}, cfg.deadband});
   assign diff   = s_e - p_e;
   assign mag    = sample[SAMPLE_WIDTH-1] ? -s_e : s_e;
   assign up     = p_e + step_e;
   assign dn     = p_e - step_e;

   // 3*|prev|/5 by reciprocal multiply, exact for this operand range
   assign p_abs = prev[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-prev) : SAMPLE_WIDTH'(prev);
   assign m3    = {p_abs, 1'b0} + MW'(p_abs);
   assign prod  = PW'(m3) * PW'(RECIP);
   assign q     = prod[SH +: SAMPLE_WIDTH];
   assign decay = prev[SAMPLE_WIDTH-1] ? -$signed(q) : $signed(q);

   always_comb begin
      if (diff > step_e) begin
         result = sat(up);
      end else if (mag < zone_e) begin
         result = decay;
      end else if (diff < -step_e) begin
         result = sat(dn);
      end else begin
         result = sample;
      end
   end

endmodule

>>> rtl/stick_slew_deadband_smoother_unit.sv
`timescale 1ns / 1ps
// Pipeline: an accepted request beat is registered in in_ff, and its result in
// out_ff. Throughput: one beat per cycle while rsp_stall is low;
// the per-channel decay multiply sets the path.
// Reset (synchronous): valids clear, last values go to zero, slew_step to 10
// and deadband to 8.

module stick_slew_deadband_smoother_unit #(
   parameter int SAMPLE_WIDTH = ssd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [ssd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ssd_pkg::REG_WIDTH-1:0]           csr_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_chan_a_in,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_chan_b_in,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_chan_c_in,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_chan_d_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_chan_a_out,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_chan_b_out,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_chan_c_out,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_chan_d_out
);
   import ssd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic                                       in_v_ff;
   logic                                       in_v_in;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  in_ff;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  in_in;
   logic                                       out_v_ff;
   logic                                       out_v_in;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  out_ff;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  last_ff;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  last_in;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  req_vec;
   logic [NUM_CHANNELS-1:0][SAMPLE_WIDTH-1:0]  res_vec;
   logic                                       advance;

   assign req_vec[0] = req_chan_a_in;
   assign req_vec[1] = req_chan_b_in;
   assign req_vec[2] = req_chan_c_in;
   assign req_vec[3] = req_chan_d_in;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      ssd_chan #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_chan (
         .cfg    (cfg_ff),
         .sample ($signed(in_ff[i])),
         .prev   ($signed(last_ff[i])),
         .result (res_vec[i])
      );
   end

   assign advance   = in_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && !advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SLEW_STEP: cfg_in.slew_step = csr_data;
            CSR_DEADBAND:  cfg_in.deadband  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_v_in = in_v_ff;
      in_in   = in_ff;
      if (!req_stall) begin
         in_v_in = req_valid;
         in_in   = req_vec;
      end
      out_v_in = out_v_ff && rsp_stall;
      last_in  = last_ff;
      if (advance) begin
         out_v_in = 1'b1;
         last_in  = res_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{slew_step: SLEW_STEP_RESET, deadband: DEADBAND_RESET};
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         last_ff  <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         last_ff  <= last_in;
      end
      in_ff <= in_in;
      if (advance) begin
         out_ff <= res_vec;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_chan_a_out = out_ff[0];
   assign rsp_chan_b_out = out_ff[1];
   assign rsp_chan_c_out = out_ff[2];
   assign rsp_chan_d_out = out_ff[3];

`ifndef NO_ASSERTIONS
   a_stall_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && out_v_ff && rsp_stall) |-> req_stall)
      else $error("held beat not stalling the request side");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat not presented");

   a_last_matches_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_ff == last_ff))
      else $error("channel history differs from presented beat");

   a_no_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("request side stalled right after reset");
`endif

endmodule
